@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication check, held off while in reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property violated");
// Invariant: expression true at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif

`endif

@@ src/ppi_pkg.sv @@
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, sizes and the RGB888 to BGR555 packing for the palette indexer.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COMP_W        = 8;
  localparam int CODE_W        = 16;
  localparam int IDX_W         = 8;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ppi_state_t;

  // search outcome, valid for one cycle when done is set
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] idx;
    logic              added;
    logic              over;
  } ppi_res_t;

  // top five bits of each component, green bit 2 in the spare top bit
  function automatic logic [CODE_W-1:0] to_bgr555(
    input logic [COMP_W-1:0] r,
    input logic [COMP_W-1:0] g,
    input logic [COMP_W-1:0] b
  );
    return {g[2], b[7:3], g[7:3], r[7:3]};
  endfunction

endpackage

@@ src/pixel_palette_indexer.sv @@
// ----------------------------------------------------------------------------
// pixel_palette_indexer
// RGB888 pixel to BGR555 code, looked up in (or appended to) a 256-entry
// palette held in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
// Operation: the pixel is packed and held at accept; the scan then compares
//   palette entries in insertion order, up to the first match or, on a miss,
//   every entry held; it reads one memory entry per cycle. out_valid then
//   strobes the registered result. No request is taken while busy is high.
// Busy drops in the strobe cycle, so the next request may be taken there.
// Reset (rst_n low, synchronous) empties the palette; no clearing pass.
// Results cannot be held off: each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_palette_indexer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ppi_pkg::COMP_W-1:0]    in_red,
  input  logic [ppi_pkg::COMP_W-1:0]    in_green,
  input  logic [ppi_pkg::COMP_W-1:0]    in_blue,
  output logic                          out_valid,
  output logic [ppi_pkg::IDX_W-1:0]     out_color_index,
  output logic [ppi_pkg::CODE_W-1:0]    out_color_code,
  output logic                          out_added_new,
  output logic                          out_overflowed
);
  import ppi_pkg::*;

  logic              accept;
  logic [CODE_W-1:0] code_r;
  ppi_res_t          res;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_added_r;
  logic              out_over_r;

  // request taken only when the search engine is idle
  assign accept = start && !busy;

  // pixel is packed once at accept and held for the whole scan
  always_ff @(posedge clk) begin
    if (accept) code_r <= to_bgr555(in_red, in_green, in_blue);
  end

  ppi_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .code  (code_r),
    .busy  (busy),
    .res   (res)
  );

  // result register: strobe for one cycle after the search finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_idx_r   <= IDX_W'(res.idx);
      out_code_r  <= code_r;
      out_added_r <= res.added;
      out_over_r  <= res.over;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;
  assign out_color_code  = out_code_r;
  assign out_added_new   = out_added_r;
  assign out_overflowed  = out_over_r;

  // a request always passes through the scan state, so strobes never abut
  `ASSERT_PROP(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r)
  `ASSERT_PROP(a_accept_busy, clk, rst_n, accept |=> busy)

endmodule

@@ src/ppi_search.sv @@
// ----------------------------------------------------------------------------
// ppi_search
// Palette store and linear search engine: one entry read per cycle, append
// on miss unless the palette is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppi_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ppi_pkg::CODE_W-1:0]    code,
  output logic                          busy,
  output ppi_pkg::ppi_res_t             res
);
  import ppi_pkg::*;

  logic [CODE_W-1:0] mem [PALETTE_DEPTH];
  logic [CODE_W-1:0] rd_data_r;

  ppi_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  issue_ptr_r, issue_ptr_nxt;
  logic [ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;

  logic hit, all_issued, full, wr_en;

  assign hit        = cmp_vld_r && (rd_data_r == code);
  assign all_issued = (issue_ptr_r == count_r);
  assign full       = (count_r == CNT_W'(PALETTE_DEPTH));
  assign busy       = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || all_issued) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    issue_ptr_nxt = issue_ptr_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    res           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) issue_ptr_nxt = '0;
      end
      ST_SCAN: begin
        if (hit) begin
          res.done = 1'b1;
          res.idx  = cmp_idx_r;
        end else if (all_issued) begin
          res.done = 1'b1;
          if (full) begin
            res.over = 1'b1;
          end else begin
            res.added = 1'b1;
            res.idx   = count_r[ADDR_W-1:0];
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end else begin
          // issue next read; data lands next cycle for compare
          issue_ptr_nxt = issue_ptr_r + CNT_W'(1);
          cmp_idx_nxt   = issue_ptr_r[ADDR_W-1:0];
          cmp_vld_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_ptr_r <= '0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_ptr_r <= issue_ptr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
  end

  // palette store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[ADDR_W-1:0]] <= code;
    rd_data_r <= mem[issue_ptr_r[ADDR_W-1:0]];
  end

  `ASSERT_ALWAYS(a_count_le_depth, clk, rst_n, count_r <= CNT_W'(PALETTE_DEPTH))
  `ASSERT_ALWAYS(a_ptr_le_count, clk, rst_n, issue_ptr_r <= count_r)
  `ASSERT_PROP(a_add_not_over, clk, rst_n, res.added |-> (res.done && !res.over))
  `ASSERT_PROP(a_add_grows, clk, rst_n, res.added |=> (count_r == $past(count_r) + CNT_W'(1)))

endmodule

@@ tb/sv/pixel_palette_indexer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_palette_indexer_test
// Drives pixel requests into the palette indexer and checks every result
// against a behavioural palette kept alongside: corner pixels first, then
// repeated colours, a fill to capacity, traffic on a full palette and a
// closing stretch with requests back to back.
// ----------------------------------------------------------------------------
module pixel_palette_indexer_test;
  import ppi_pkg::*;

  localparam int STALL_LIMIT  = 4000;  // well beyond a full scan, plus idle bursts
  localparam int DRAIN_CYCLES = 300;   // past the longest scan

  // one expected lookup outcome
  typedef struct {
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] code;
    logic              added;
    logic              over;
  } lookup_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [COMP_W-1:0] in_red;
  logic [COMP_W-1:0] in_green;
  logic [COMP_W-1:0] in_blue;
  logic              out_valid;
  logic [IDX_W-1:0]  out_color_index;
  logic [CODE_W-1:0] out_color_code;
  logic              out_added_new;
  logic              out_overflowed;

  // behavioural palette: codes in order of insertion and how many are held
  logic [CODE_W-1:0] pal_codes [PALETTE_DEPTH];
  int                pal_count;

  lookup_t           pending_lookups [$];
  int                mismatches;
  bit                idle_on;

  pixel_palette_indexer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_color_index (out_color_index),
    .out_color_code  (out_color_code),
    .out_added_new   (out_added_new),
    .out_overflowed  (out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Palette model
  // --------------------------------------------------------------------------

  // top five bits of each component; green bit 2 rides in bit 15
  function automatic logic [CODE_W-1:0] bgr555_of(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
    logic [31:0] packed_code;
    packed_code = ((32'(r) & 32'hf8) >> 3)
                | ((32'(g) & 32'hf8) << 2)
                | ((32'(b) & 32'hf8) << 7)
                | ((32'(g) & 32'h04) << 13);
    return packed_code[CODE_W-1:0];
  endfunction

  // first matching entry, or -1 when the code is not held
  function automatic int palette_find(logic [CODE_W-1:0] code);
    for (int i = 0; i < pal_count; i++)
      if (pal_codes[i] == code) return i;
    return -1;
  endfunction

  // update the palette for one accepted request and queue its outcome
  function automatic void predict_lookup(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    lookup_t want;
    int      hit;
    want.code  = bgr555_of(r, g, b);
    want.added = 1'b0;
    want.over  = 1'b0;
    hit = palette_find(want.code);
    if (hit >= 0) begin
      want.index = IDX_W'(hit);
    end else if (pal_count >= PALETTE_DEPTH) begin
      // full and no match: palette untouched, index 0
      want.index = '0;
      want.over  = 1'b1;
    end else begin
      pal_codes[pal_count] = want.code;
      want.index = IDX_W'(pal_count);
      want.added = 1'b1;
      pal_count++;
    end
    pending_lookups.push_back(want);
  endfunction

  // any pixel mapping to the code; the discarded low bits are random
  function automatic void pixel_for_code(input logic [CODE_W-1:0] code,
                                         output logic [7:0] r, output logic [7:0] g,
                                         output logic [7:0] b);
    r = {code[4:0], 3'($urandom)};
    g = {code[9:5], code[15], 2'($urandom)};
    b = {code[14:10], 3'($urandom)};
  endfunction

  function automatic logic [CODE_W-1:0] fresh_code();
    logic [CODE_W-1:0] code;
    do code = CODE_W'($urandom); while (palette_find(code) >= 0);
    return code;
  endfunction

  function automatic logic [CODE_W-1:0] held_code();
    return pal_codes[$urandom_range(0, pal_count - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------

  // start stays high between back-to-back requests; it only drops for an
  // idle burst, so it never sees two assignments in one step
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lookup(r, g, b);
  endtask

  task automatic send_code(input logic [CODE_W-1:0] code);
    logic [7:0] r, g, b;
    pixel_for_code(code, r, g, b);
    send_pixel(r, g, b);
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // results cannot be held off: every strobe cycle is a result
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx=%0d code=%h",
                                  out_color_index, out_color_code));
      end else begin
        want = pending_lookups.pop_front();
        if (out_color_index !== want.index)
          report_mismatch($sformatf("color_index got %0d want %0d (code %h)",
                                    out_color_index, want.index, want.code));
        if (out_color_code !== want.code)
          report_mismatch($sformatf("color_code got %h want %h",
                                    out_color_code, want.code));
        if (out_added_new !== want.added)
          report_mismatch($sformatf("added_new got %b want %b (code %h)",
                                    out_added_new, want.added, want.code));
        if (out_overflowed !== want.over)
          report_mismatch($sformatf("overflowed got %b want %b (code %h)",
                                    out_overflowed, want.over, want.code));
      end
    end
  end

  // watchdog: too long with neither a request taken nor a result strobed
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall = 0;
      else stall++;
    end
    $display("pixel_palette_indexer: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // extremes, single components, low bits that drop out, green bit 2
  task automatic test_corner_pixels();
    send_pixel(8'h00, 8'h00, 8'h00);  // first entry
    send_pixel(8'h00, 8'h00, 8'h00);  // hit on entry 0
    send_pixel(8'h07, 8'h03, 8'h07);  // discarded bits only: still entry 0
    send_pixel(8'h00, 8'h04, 8'h00);  // green bit 2 alone gives a new code
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hfb, 8'h00);  // green top bits, bit 2 clear
    send_pixel(8'hf8, 8'hf8, 8'hf8);
    send_pixel(8'h08, 8'h00, 8'h00);  // lowest kept red bit
    send_pixel(8'hff, 8'hff, 8'hff);  // hit further down the list
    send_pixel(8'h01, 8'h02, 8'h01);  // back to entry 0
  endtask

  // mostly colours already held, some new ones
  task automatic test_repeated_colours();
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(0, 3) != 0) send_code(held_code());
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // append until full, with hits mixed in so the scan runs deep
  task automatic test_palette_fill();
    while (pal_count < PALETTE_DEPTH) begin
      if ($urandom_range(0, 4) == 0) send_code(held_code());
      else send_code(fresh_code());
    end
    send_code(pal_codes[PALETTE_DEPTH-1]);  // last slot, longest scan
    send_code(pal_codes[0]);
  endtask

  // full palette: hits keep their index, misses overflow to index 0
  task automatic test_full_palette();
    send_code(fresh_code());
    send_code(pal_codes[PALETTE_DEPTH-1]);
    for (int i = 0; i < 250; i++) begin
      if ($urandom_range(0, 2) == 0) send_code(fresh_code());
      else send_code(held_code());
    end
  endtask

  // no idle bursts: requests taken in the strobe cycle of the previous one
  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int i = 0; i < 80; i++) begin
      if ($urandom_range(0, 3) == 0) send_code(fresh_code());
      else send_code(held_code());
    end
  endtask

  initial begin
    mismatches = 0;
    pal_count  = 0;
    idle_on    = 1'b1;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_red   <= '0;
    in_green <= '0;
    in_blue  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_pixels();
    test_repeated_colours();
    test_palette_fill();
    test_full_palette();
    test_back_to_back();

    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("pixel_palette_indexer: match");
    else
      $display("pixel_palette_indexer: mismatch");
    $finish;
  end

endmodule
